@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold whenever the antecedent holds in the same cycle
`define MSRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after the antecedent
`define MSRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/msrs_pkg.sv @@
// types and constants of the motor stroke ramp sequencer
package msrs_pkg;

  localparam int unsigned MAX_DUTY_DEF  = 500;
  localparam int unsigned DUTY_STEP_DEF = 50;

  localparam logic [7:0]  STROKE_COUNT_RST = 8'd10;
  localparam logic        PRESSURE_REL_RST = 1'b1;
  localparam logic [15:0] PEAK_DUTY_RST    = 16'd0;
  localparam logic [15:0] STEP_HOLD_RST    = 16'd50;
  localparam logic [15:0] FWD_DWELL_RST    = 16'd1000;
  localparam logic [15:0] REV_DWELL_RST    = 16'd200;
  localparam logic [7:0]  STROKES_MAX      = 8'hFF;

  typedef enum logic [3:0] {
    PH_FWD_UP    = 4'd0,
    PH_FWD_WAIT  = 4'd1,
    PH_FWD_DOWN  = 4'd2,
    PH_FWD_DWELL = 4'd3,
    PH_REV_UP    = 4'd4,
    PH_REV_WAIT  = 4'd5,
    PH_REV_DOWN  = 4'd6,
    PH_REV_DWELL = 4'd7,
    PH_DONE      = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    CFG_STROKE_COUNT = 3'd0,
    CFG_PRESSURE_REL = 3'd1,
    CFG_PEAK_DUTY    = 3'd2,
    CFG_STEP_HOLD    = 3'd3,
    CFG_FWD_DWELL    = 3'd4,
    CFG_REV_DWELL    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  stroke_count;
    logic        release_en;
    logic [15:0] peak_duty;
    logic [15:0] step_hold_ticks;
    logic [15:0] forward_dwell_ticks;
    logic [15:0] reverse_dwell_ticks;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] hold;
    logic [7:0]  strokes;
    logic        last;
    logic [8:0]  fwd;
    logic [8:0]  rev;
  } seq_state_t;

endpackage

@@ rtl/core/msrs_step.sv @@
// next-state logic of the sequencer for one tick
module msrs_step #(
  parameter int unsigned MAX_DUTY  = msrs_pkg::MAX_DUTY_DEF,
  parameter int unsigned DUTY_STEP = msrs_pkg::DUTY_STEP_DEF,
  localparam int unsigned DUTY_W   = $clog2(MAX_DUTY + DUTY_STEP + 1)
) (
  input  msrs_pkg::cfg_t       cfg_i,
  input  logic                 home_sensor_i,
  input  logic                 end_sensor_i,
  input  logic                 stop_sensor_i,
  input  msrs_pkg::seq_state_t st_i,
  input  logic [DUTY_W-1:0]    duty_i,
  output msrs_pkg::seq_state_t st_o,
  output logic [DUTY_W-1:0]    duty_o
);
  import msrs_pkg::*;

  localparam logic [16:0]       MAX_W  = 17'(MAX_DUTY);
  localparam logic [DUTY_W-1:0] STEP_W = DUTY_W'(DUTY_STEP);

  typedef struct packed {
    phase_e            phase;
    logic [DUTY_W-1:0] duty;
    logic [15:0]       hold;
    logic [7:0]        strokes;
    logic              last;
    logic [8:0]        fwd;
    logic [8:0]        rev;
  } st_t;

  typedef struct packed {
    logic              home;
    logic              end_s;
    logic              stop;
    logic [DUTY_W-1:0] tgt;
    logic [15:0]       hold_lim;
    logic [7:0]        count;
    logic              rel;
    logic [15:0]       fdw;
    logic [15:0]       rdw;
  } env_t;

  env_t env;
  st_t  cur;
  st_t  nxt;

  function automatic phase_e next_ph(phase_e p);
    return phase_e'(p + 4'd1);
  endfunction

  // one ramp-up tick
  function automatic st_t ru_f(st_t s, logic rev, env_t e);
    st_t         r;
    logic [16:0] h1;
    r  = s;
    h1 = {1'b0, s.hold} + 17'd1;
    r.fwd = rev ? 9'd0 : 9'(s.duty);
    r.rev = rev ? 9'(s.duty) : 9'd0;
    if (h1 >= {1'b0, e.hold_lim}) begin
      r.hold = '0;
      r.duty = s.duty + STEP_W;
      if (r.duty > e.tgt) begin
        r.phase = next_ph(s.phase);
      end
    end else begin
      r.hold = h1[15:0];
    end
    return r;
  endfunction

  // stroke start, duty and hold already zero
  function automatic st_t start_f(st_t s, env_t e);
    st_t r;
    r = s;
    if (s.strokes >= e.count) begin
      r.phase = PH_DONE;
      r.fwd   = '0;
      r.rev   = '0;
      return r;
    end
    r.phase = PH_FWD_UP;
    r.last  = e.rel && (({1'b0, s.strokes} + 9'd1) == {1'b0, e.count});
    return ru_f(r, 1'b0, e);
  endfunction

  function automatic st_t dwell_f(st_t s, logic rev, env_t e);
    st_t         r;
    logic [15:0] dw;
    r     = s;
    dw    = rev ? e.rdw : e.fdw;
    r.fwd = '0;
    r.rev = '0;
    if (s.hold >= dw) begin
      r.duty = '0;
      r.hold = '0;
      if (rev || s.last) begin
        if (s.strokes != STROKES_MAX) begin
          r.strokes = s.strokes + 8'd1;
        end
        r.phase = PH_FWD_UP;
        return start_f(r, e);
      end
      r.phase = PH_REV_UP;
      return ru_f(r, 1'b1, e);
    end
    r.hold = s.hold + 16'd1;
    return r;
  endfunction

  function automatic st_t rd_f(st_t s, logic rev, env_t e);
    st_t         r;
    logic [16:0] h1;
    r  = s;
    h1 = {1'b0, s.hold} + 17'd1;
    if (s.hold == '0 && (e.end_s || e.home)) begin
      r.fwd   = '0;
      r.rev   = '0;
      r.phase = next_ph(s.phase);
      r.duty  = '0;
      r.hold  = '0;
      return dwell_f(r, rev, e);
    end
    r.fwd = rev ? 9'd0 : 9'(s.duty);
    r.rev = rev ? 9'(s.duty) : 9'd0;
    if (h1 >= {1'b0, e.hold_lim}) begin
      r.hold = '0;
      if (s.duty < STEP_W) begin
        r.phase = next_ph(s.phase);
        r.duty  = '0;
      end else begin
        r.duty = s.duty - STEP_W;
      end
    end else begin
      r.hold = h1[15:0];
    end
    return r;
  endfunction

  function automatic st_t wait_f(st_t s, logic rev, env_t e);
    st_t  r;
    logic hit;
    r   = s;
    hit = rev ? e.home : (s.last ? e.stop : e.end_s);
    if (hit) begin
      r.phase = next_ph(s.phase);
      r.duty  = e.tgt;
      r.hold  = '0;
      return rd_f(r, rev, e);
    end
    return r;
  endfunction

  always_comb begin
    env.home     = home_sensor_i;
    env.end_s    = end_sensor_i;
    env.stop     = stop_sensor_i;
    env.hold_lim = (cfg_i.step_hold_ticks == '0) ? 16'd1 : cfg_i.step_hold_ticks;
    env.count    = cfg_i.stroke_count;
    env.rel      = cfg_i.release_en;
    env.fdw      = cfg_i.forward_dwell_ticks;
    env.rdw      = cfg_i.reverse_dwell_ticks;
    if (cfg_i.peak_duty == '0 || {1'b0, cfg_i.peak_duty} > MAX_W) begin
      env.tgt = DUTY_W'(MAX_DUTY);
    end else begin
      env.tgt = DUTY_W'(cfg_i.peak_duty);
    end
  end

  always_comb begin
    cur.phase   = st_i.phase;
    cur.duty    = duty_i;
    cur.hold    = st_i.hold;
    cur.strokes = st_i.strokes;
    cur.last    = st_i.last;
    cur.fwd     = st_i.fwd;
    cur.rev     = st_i.rev;
    case (st_i.phase)
      PH_FWD_UP: begin
        if (cur.hold == '0 && cur.duty == '0) begin
          nxt = start_f(cur, env);
        end else begin
          nxt = ru_f(cur, 1'b0, env);
        end
      end
      PH_REV_UP:    nxt = ru_f(cur, 1'b1, env);
      PH_FWD_WAIT:  nxt = wait_f(cur, 1'b0, env);
      PH_REV_WAIT:  nxt = wait_f(cur, 1'b1, env);
      PH_FWD_DOWN:  nxt = rd_f(cur, 1'b0, env);
      PH_REV_DOWN:  nxt = rd_f(cur, 1'b1, env);
      PH_FWD_DWELL: nxt = dwell_f(cur, 1'b0, env);
      PH_REV_DWELL: nxt = dwell_f(cur, 1'b1, env);
      default: begin
        // done: a raised stroke count starts a new stroke
        cur.duty = '0;
        cur.hold = '0;
        nxt = start_f(cur, env);
      end
    endcase
  end

  assign st_o.phase   = nxt.phase;
  assign st_o.hold    = nxt.hold;
  assign st_o.strokes = nxt.strokes;
  assign st_o.last    = nxt.last;
  assign st_o.fwd     = nxt.fwd;
  assign st_o.rev     = nxt.rev;
  assign duty_o       = nxt.duty;

endmodule

@@ rtl/core/motor_stroke_ramp_sequencer_core.sv @@
// top level of the motor stroke ramp sequencer
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  in       | in_valid_i / in_stall_o    | home, end and stop sensor levels
//  out      | out_valid_o / out_stall_i  | forward/reverse duty, phase, strokes, done
//  cfg      | cfg_wr_en_i                | cfg_index_i, cfg_wdata_i
//
// one transaction per cycle sustained while the output is not stalled; a tick waits in the input register,
// then its state update lands in the state register, which is also the result register
// reset clears the state and both valid flags and sets the configuration registers to their defaults
// a stalled result holds the state; the input register still takes one more tick if it is empty
module motor_stroke_ramp_sequencer_core #(
  parameter int unsigned MAX_DUTY  = msrs_pkg::MAX_DUTY_DEF,
  parameter int unsigned DUTY_STEP = msrs_pkg::DUTY_STEP_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        home_sensor_i,
  input  logic        end_sensor_i,
  input  logic        stop_sensor_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [8:0]  forward_duty_o,
  output logic [8:0]  reverse_duty_o,
  output logic [3:0]  phase_o,
  output logic [7:0]  strokes_done_o,
  output logic        all_done_o
);
  import msrs_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned DUTY_W = $clog2(MAX_DUTY + DUTY_STEP + 1);

  cfg_t              cfg_q;
  seq_state_t        st_q;
  seq_state_t        st_d;
  logic [DUTY_W-1:0] duty_q;
  logic [DUTY_W-1:0] duty_d;
  logic              s1_valid_q;
  logic              home_q;
  logic              end_q;
  logic              stop_q;
  logic              out_valid_q;
  logic              accept;
  logic              adv;

  assign adv        = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~adv;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stroke_count        <= STROKE_COUNT_RST;
      cfg_q.release_en          <= PRESSURE_REL_RST;
      cfg_q.peak_duty           <= PEAK_DUTY_RST;
      cfg_q.step_hold_ticks     <= STEP_HOLD_RST;
      cfg_q.forward_dwell_ticks <= FWD_DWELL_RST;
      cfg_q.reverse_dwell_ticks <= REV_DWELL_RST;
    end else if (cfg_wr_en_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STROKE_COUNT: cfg_q.stroke_count        <= cfg_wdata_i[7:0];
        CFG_PRESSURE_REL: cfg_q.release_en          <= cfg_wdata_i[0];
        CFG_PEAK_DUTY:    cfg_q.peak_duty           <= cfg_wdata_i;
        CFG_STEP_HOLD:    cfg_q.step_hold_ticks     <= cfg_wdata_i;
        CFG_FWD_DWELL:    cfg_q.forward_dwell_ticks <= cfg_wdata_i;
        CFG_REV_DWELL:    cfg_q.reverse_dwell_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      home_q <= home_sensor_i;
      end_q  <= end_sensor_i;
      stop_q <= stop_sensor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= accept | (s1_valid_q & ~adv);
      out_valid_q <= adv | (out_valid_q & out_stall_i);
    end
  end

  msrs_step #(
    .MAX_DUTY  (MAX_DUTY),
    .DUTY_STEP (DUTY_STEP)
  ) u_step (
    .cfg_i         (cfg_q),
    .home_sensor_i (home_q),
    .end_sensor_i  (end_q),
    .stop_sensor_i (stop_q),
    .st_i          (st_q),
    .duty_i        (duty_q),
    .st_o          (st_d),
    .duty_o        (duty_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase   <= PH_FWD_UP;
      st_q.hold    <= '0;
      st_q.strokes <= '0;
      st_q.last    <= 1'b0;
      st_q.fwd     <= '0;
      st_q.rev     <= '0;
      duty_q       <= '0;
    end else if (adv) begin
      st_q   <= st_d;
      duty_q <= duty_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign forward_duty_o = st_q.fwd;
  assign reverse_duty_o = st_q.rev;
  assign phase_o        = st_q.phase;
  assign strokes_done_o = st_q.strokes;
  assign all_done_o     = (st_q.phase == PH_DONE);

  `MSRS_ASSERT_NOW(a_done_idle, out_valid_o && all_done_o,
    forward_duty_o == '0 && reverse_duty_o == '0, "duty driven while done")
  `MSRS_ASSERT_NOW(a_fwd_no_rev,
    st_q.phase == PH_FWD_UP || st_q.phase == PH_FWD_WAIT ||
    st_q.phase == PH_FWD_DOWN || st_q.phase == PH_FWD_DWELL,
    reverse_duty_o == '0, "reverse duty in forward phase")
  `MSRS_ASSERT_NOW(a_rev_no_fwd,
    st_q.phase == PH_REV_UP || st_q.phase == PH_REV_WAIT || st_q.phase == PH_REV_DOWN,
    forward_duty_o == '0, "forward duty in reverse phase")
  `MSRS_ASSERT_NEXT(a_strokes_mono, adv,
    st_q.strokes >= $past(st_q.strokes), "stroke count went backwards")

endmodule
